/* hdl/tfm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared widths, constants, types and helper functions for the triangle
// flatness metrics block.
// ----------------------------------------------------------------------------
package tfm_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int OUT_W   = 32;
  localparam int ANG_W   = 18;
  localparam int REF_W   = 16;
  localparam int IDX_W   = 2;

  // datapath widths
  localparam int HSUM_W  = 33;
  localparam int EDGE_W  = 33;
  localparam int PROD_W  = 66;
  localparam int CROSS_W = 67;
  localparam int MAG_W   = 65;
  localparam int LEN_W   = 7;
  localparam int NRM_W   = 24;
  localparam int SQ_W    = 48;
  localparam int DPROD_W = 41;
  localparam int DOT_W   = 43;
  localparam int DMAG_W  = 42;
  localparam int RAD_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int REM_W   = 33;
  localparam int DIVD_W  = 64;
  localparam int QUO_W   = 35;
  localparam int DSR_W   = 31;
  localparam int COS_W   = 31;
  localparam int CX_W    = 34;
  localparam int CZ_W    = 28;
  localparam int ANGZ_W  = 26;

  // cell counts
  localparam int SQRT_STEPS   = ROOT_W;
  localparam int DIV_STEPS    = QUO_W;
  localparam int CORDIC_STEPS = 24;
  localparam int PIPE_DEPTH   = 9 + SQRT_STEPS + DIV_STEPS + 3 + SQRT_STEPS + CORDIC_STEPS + 1;

  // constants
  localparam logic [HSUM_W-1:0] MEAN_RECIP  = 33'h1_5555_5556;  // ceil(2^34 / 3)
  localparam logic [QUO_W-1:0]  ONE_Q30     = 35'h0_4000_0000;
  localparam logic [RAD_W-1:0]  ONE_Q60     = 62'h1000_0000_0000_0000;
  localparam logic [ANGZ_W-1:0] Q24_PI      = 26'd52707179;
  localparam logic [ANGZ_W-1:0] Q24_HALF_PI = 26'd26353589;
  localparam logic [ANG_W-1:0]  Q16_HALF_PI = 18'd102944;
  localparam logic [ANG_W-1:0]  Q16_PI_MAX  = 18'd205887;

  localparam logic signed [REF_W-1:0] REF_X_RESET = 16'sd0;
  localparam logic signed [REF_W-1:0] REF_Y_RESET = 16'sd0;
  localparam logic signed [REF_W-1:0] REF_Z_RESET = 16'sd16384;

  typedef enum logic [IDX_W-1:0] {
    REG_REF_NX = 2'd0,
    REG_REF_NY = 2'd1,
    REG_REF_NZ = 2'd2
  } cfg_reg_t;

  // per-item data that rides alongside the cell chains
  typedef struct packed {
    logic              degen;
    logic              dneg;
    logic [DMAG_W-1:0] dmag;
    logic [COS_W-1:0]  cosq;
    logic [OUT_W-1:0]  mean;
    logic [OUT_W-1:0]  spread;
  } side_t;

  // number of significant bits
  function automatic logic [LEN_W-1:0] bitlen(input logic [MAG_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) begin
        n = LEN_W'(i + 1);
      end
    end
    return n;
  endfunction

  // atan(2^-i) in Q0.24
  function automatic logic [23:0] atan_q24(input int unsigned i);
    logic [23:0] a;
    unique case (i)
      0:  a = 24'd13176795;
      1:  a = 24'd7778716;
      2:  a = 24'd4110060;
      3:  a = 24'd2086331;
      4:  a = 24'd1047214;
      5:  a = 24'd524117;
      6:  a = 24'd262123;
      7:  a = 24'd131069;
      8:  a = 24'd65536;
      9:  a = 24'd32768;
      10: a = 24'd16384;
      11: a = 24'd8192;
      12: a = 24'd4096;
      13: a = 24'd2048;
      14: a = 24'd1024;
      15: a = 24'd512;
      16: a = 24'd256;
      17: a = 24'd128;
      18: a = 24'd64;
      19: a = 24'd32;
      20: a = 24'd16;
      21: a = 24'd8;
      22: a = 24'd4;
      23: a = 24'd2;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

endpackage

/* hdl/triangle_flatness_metrics.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_flatness_metrics
// Per-triangle mean absolute height, height spread and tilt angle against a
// programmable reference normal.
// ----------------------------------------------------------------------------
// The block takes one triangle per cycle while in_ready is high and returns
// one result per triangle, in order. The pipeline is built from chains of
// cells: a nine-stage front end (edges, cross product, normalize, squares
// and dot product), a 31-cell square root for the normal length, a 35-cell
// divider for the cosine, three stages to form 1 - cos^2, a second 31-cell
// square root for the sine and a 24-cell arctangent chain, then one stage
// to fold and round the angle. An output register with a one-entry skid
// stage lets a new transaction in while a result waits; the pipeline only
// stalls once both are full. The reference normal registers are always
// ready and must only be written while no triangle is in flight.
// ----------------------------------------------------------------------------
module triangle_flatness_metrics (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tfm_pkg::IDX_W-1:0]          cfg_index,
  input  logic [tfm_pkg::REF_W-1:0]          cfg_data,
  // triangle input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tfm_pkg::COORD_W-1:0] p0_x,
  input  logic signed [tfm_pkg::COORD_W-1:0] p0_y,
  input  logic signed [tfm_pkg::COORD_W-1:0] p0_z,
  input  logic signed [tfm_pkg::COORD_W-1:0] p1_x,
  input  logic signed [tfm_pkg::COORD_W-1:0] p1_y,
  input  logic signed [tfm_pkg::COORD_W-1:0] p1_z,
  input  logic signed [tfm_pkg::COORD_W-1:0] p2_x,
  input  logic signed [tfm_pkg::COORD_W-1:0] p2_y,
  input  logic signed [tfm_pkg::COORD_W-1:0] p2_z,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tfm_pkg::OUT_W-1:0]          mean_abs_height,
  output logic [tfm_pkg::ANG_W-1:0]          tilt_angle,
  output logic [tfm_pkg::OUT_W-1:0]          height_spread
);
  import tfm_pkg::*;

  localparam int SIDE_W = $bits(side_t);

  // pipeline advance: the whole pipe moves unless the skid entry is taken
  logic en;
  logic skid_valid;
  logic [PIPE_DEPTH-1:0] vld;

  // reference normal registers
  logic signed [REF_W-1:0] ref_n [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_n[0] <= REF_X_RESET;
      ref_n[1] <= REF_Y_RESET;
      ref_n[2] <= REF_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REF_NX: ref_n[0] <= cfg_data;
        REG_REF_NY: ref_n[1] <= cfg_data;
        REG_REF_NZ: ref_n[2] <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid && in_ready};
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: edges, absolute height sum, height spread
  // --------------------------------------------------------------------------
  logic signed [EDGE_W-1:0]  e1_c [3];
  logic signed [EDGE_W-1:0]  e2_c [3];
  logic [COORD_W-1:0]        a0, a1, a2;
  logic signed [COORD_W-1:0] zmax, zmin;
  logic [HSUM_W-1:0]         hsum_c;

  logic signed [EDGE_W-1:0] s1_e1 [3];
  logic signed [EDGE_W-1:0] s1_e2 [3];
  logic [HSUM_W-1:0]        s1_hsum;
  logic [OUT_W-1:0]         s1_spread;

  always_comb begin
    e1_c[0] = {p1_x[COORD_W-1], p1_x} - {p0_x[COORD_W-1], p0_x};
    e1_c[1] = {p1_y[COORD_W-1], p1_y} - {p0_y[COORD_W-1], p0_y};
    e1_c[2] = {p1_z[COORD_W-1], p1_z} - {p0_z[COORD_W-1], p0_z};
    e2_c[0] = {p2_x[COORD_W-1], p2_x} - {p0_x[COORD_W-1], p0_x};
    e2_c[1] = {p2_y[COORD_W-1], p2_y} - {p0_y[COORD_W-1], p0_y};
    e2_c[2] = {p2_z[COORD_W-1], p2_z} - {p0_z[COORD_W-1], p0_z};
    a0 = p0_z[COORD_W-1] ? (~p0_z + 1'b1) : p0_z;
    a1 = p1_z[COORD_W-1] ? (~p1_z + 1'b1) : p1_z;
    a2 = p2_z[COORD_W-1] ? (~p2_z + 1'b1) : p2_z;
    hsum_c = HSUM_W'(a0) + HSUM_W'(a1) + HSUM_W'(a2);
    zmax = p0_z;
    zmin = p0_z;
    if (p1_z > zmax) zmax = p1_z;
    if (p2_z > zmax) zmax = p2_z;
    if (p1_z < zmin) zmin = p1_z;
    if (p2_z < zmin) zmin = p2_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_e1     <= e1_c;
      s1_e2     <= e2_c;
      s1_hsum   <= hsum_c;
      s1_spread <= OUT_W'(zmax - zmin);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: cross product partial products, mean by reciprocal of three
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] s2_pa [3];
  logic signed [PROD_W-1:0] s2_pb [3];
  logic [PROD_W-1:0]        mean_prod;
  logic [OUT_W-1:0]         s2_mean, s2_spread;

  assign mean_prod = PROD_W'(s1_hsum) * PROD_W'(MEAN_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pa[0]  <= s1_e1[1] * s1_e2[2];
      s2_pb[0]  <= s1_e1[2] * s1_e2[1];
      s2_pa[1]  <= s1_e1[2] * s1_e2[0];
      s2_pb[1]  <= s1_e1[0] * s1_e2[2];
      s2_pa[2]  <= s1_e1[0] * s1_e2[1];
      s2_pb[2]  <= s1_e1[1] * s1_e2[0];
      s2_mean   <= mean_prod[PROD_W-1 -: OUT_W];
      s2_spread <= s1_spread;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: exact cross product
  // --------------------------------------------------------------------------
  logic signed [CROSS_W-1:0] s3_c [3];
  logic [OUT_W-1:0]          s3_mean, s3_spread;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_c[i] <= CROSS_W'(s2_pa[i]) - CROSS_W'(s2_pb[i]);
      end
      s3_mean   <= s2_mean;
      s3_spread <= s2_spread;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: sign and magnitude
  // --------------------------------------------------------------------------
  logic [CROSS_W-1:0] cneg [3];
  logic [MAG_W-1:0]   s4_mag [3];
  logic               s4_neg [3];
  logic [MAG_W-1:0]   s4_or;
  logic [OUT_W-1:0]   s4_mean, s4_spread;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cneg[i] = -s3_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_neg[i] <= s3_c[i][CROSS_W-1];
        s4_mag[i] <= s3_c[i][CROSS_W-1] ? cneg[i][MAG_W-1:0] : s3_c[i][MAG_W-1:0];
      end
      s4_or <= (s3_c[0][CROSS_W-1] ? cneg[0][MAG_W-1:0] : s3_c[0][MAG_W-1:0])
             | (s3_c[1][CROSS_W-1] ? cneg[1][MAG_W-1:0] : s3_c[1][MAG_W-1:0])
             | (s3_c[2][CROSS_W-1] ? cneg[2][MAG_W-1:0] : s3_c[2][MAG_W-1:0]);
      s4_mean   <= s3_mean;
      s4_spread <= s3_spread;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: common bit length of the largest component
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] s5_len;
  logic [MAG_W-1:0] s5_mag [3];
  logic             s5_neg [3];
  logic [OUT_W-1:0] s5_mean, s5_spread;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_len    <= bitlen(s4_or);
      s5_mag    <= s4_mag;
      s5_neg    <= s4_neg;
      s5_mean   <= s4_mean;
      s5_spread <= s4_spread;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: normalize so the largest magnitude sits in [2^23, 2^24)
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] shifted [3];
  logic [NRM_W-1:0] s6_m [3];
  logic             s6_neg [3];
  logic             s6_degen;
  logic [OUT_W-1:0] s6_mean, s6_spread;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s5_len > LEN_W'(NRM_W)) begin
        shifted[i] = s5_mag[i] >> (s5_len - LEN_W'(NRM_W));
      end else begin
        shifted[i] = s5_mag[i] << (LEN_W'(NRM_W) - s5_len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_m[i] <= shifted[i][NRM_W-1:0];
      end
      s6_neg    <= s5_neg;
      s6_degen  <= (s5_len == '0);  // zero cross product
      s6_mean   <= s5_mean;
      s6_spread <= s5_spread;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: squares and dot product terms
  // --------------------------------------------------------------------------
  logic signed [NRM_W:0]     nsig [3];
  logic [SQ_W-1:0]           s7_sq [3];
  logic signed [DPROD_W-1:0] s7_dp [3];
  logic                      s7_degen;
  logic [OUT_W-1:0]          s7_mean, s7_spread;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsig[i] = s6_neg[i] ? -$signed({1'b0, s6_m[i]}) : $signed({1'b0, s6_m[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s7_sq[i] <= SQ_W'(s6_m[i]) * SQ_W'(s6_m[i]);
        s7_dp[i] <= nsig[i] * ref_n[i];
      end
      s7_degen  <= s6_degen;
      s7_mean   <= s6_mean;
      s7_spread <= s6_spread;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: squared length scaled by 2^12, dot product
  // --------------------------------------------------------------------------
  logic [RAD_W-1:0]        s8_rad;
  logic signed [DOT_W-1:0] s8_dot;
  logic                    s8_degen;
  logic [OUT_W-1:0]        s8_mean, s8_spread;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_rad    <= RAD_W'({(SQ_W + 2)'(s7_sq[0]) + (SQ_W + 2)'(s7_sq[1])
                           + (SQ_W + 2)'(s7_sq[2]), 12'b0});
      s8_dot    <= DOT_W'(s7_dp[0]) + DOT_W'(s7_dp[1]) + DOT_W'(s7_dp[2]);
      s8_degen  <= s7_degen;
      s8_mean   <= s7_mean;
      s8_spread <= s7_spread;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: dot product sign and magnitude, side data assembled
  // --------------------------------------------------------------------------
  logic [DOT_W-1:0] dot_neg;
  logic [RAD_W-1:0] s9_rad;
  side_t            side9;

  assign dot_neg = -s8_dot;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_rad       <= s8_rad;
      side9.degen  <= s8_degen;
      side9.dneg   <= s8_dot[DOT_W-1];
      side9.dmag   <= s8_dot[DOT_W-1] ? dot_neg[DMAG_W-1:0] : s8_dot[DMAG_W-1:0];
      side9.cosq   <= '0;
      side9.mean   <= s8_mean;
      side9.spread <= s8_spread;
    end
  end

  // --------------------------------------------------------------------------
  // normal length: square root cell chain
  // --------------------------------------------------------------------------
  logic [RAD_W-1:0]  r1_rad  [SQRT_STEPS+1];
  logic [REM_W-1:0]  r1_rem  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] r1_root [SQRT_STEPS+1];
  logic [SIDE_W-1:0] side_a_bits;
  side_t             side_a;

  assign r1_rad[0]  = s9_rad;
  assign r1_rem[0]  = '0;
  assign r1_root[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt_a
    tfm_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .rad_in   (r1_rad[k]),
      .rem_in   (r1_rem[k]),
      .root_in  (r1_root[k]),
      .rad_out  (r1_rad[k+1]),
      .rem_out  (r1_rem[k+1]),
      .root_out (r1_root[k+1])
    );
  end

  tfm_delay #(.W(SIDE_W), .DEPTH(SQRT_STEPS)) u_side_a (
    .clk (clk),
    .en  (en),
    .d   (side9),
    .q   (side_a_bits)
  );
  assign side_a = side_t'(side_a_bits);

  // --------------------------------------------------------------------------
  // cosine: |dot| * 2^22 / length, divider cell chain
  // --------------------------------------------------------------------------
  logic [DIVD_W-1:0] dvd;
  logic [DSR_W-1:0]  dv_rem  [DIV_STEPS+1];
  logic [QUO_W-1:0]  dv_bits [DIV_STEPS+1];
  logic [QUO_W-1:0]  dv_quo  [DIV_STEPS+1];
  logic [DSR_W-1:0]  dv_dsr  [DIV_STEPS+1];
  logic [SIDE_W-1:0] side_b_bits;
  side_t             side_b;

  assign dvd        = DIVD_W'({side_a.dmag, 22'b0});
  assign dv_rem[0]  = DSR_W'(dvd[DIVD_W-1:QUO_W]);
  assign dv_bits[0] = dvd[QUO_W-1:0];
  assign dv_quo[0]  = '0;
  assign dv_dsr[0]  = r1_root[SQRT_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    tfm_div_cell u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (dv_rem[k]),
      .bits_in  (dv_bits[k]),
      .quo_in   (dv_quo[k]),
      .dsr_in   (dv_dsr[k]),
      .rem_out  (dv_rem[k+1]),
      .bits_out (dv_bits[k+1]),
      .quo_out  (dv_quo[k+1]),
      .dsr_out  (dv_dsr[k+1])
    );
  end

  tfm_delay #(.W(SIDE_W), .DEPTH(DIV_STEPS)) u_side_b (
    .clk (clk),
    .en  (en),
    .d   (side_a),
    .q   (side_b_bits)
  );
  assign side_b = side_t'(side_b_bits);

  // --------------------------------------------------------------------------
  // clamp cosine to one, square it, form 1 - cos^2 in Q60
  // --------------------------------------------------------------------------
  logic [COS_W-1:0] qc;
  side_t            side_bq;
  side_t            side_q, side_sq, side_r;
  logic [RAD_W-1:0] sq_cos, rad_sin;

  assign qc = (dv_quo[DIV_STEPS] > ONE_Q30) ? ONE_Q30[COS_W-1:0]
                                            : dv_quo[DIV_STEPS][COS_W-1:0];

  // side data with the clamped cosine filled in
  always_comb begin
    side_bq      = side_b;
    side_bq.cosq = qc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q  <= side_bq;
      sq_cos  <= RAD_W'(side_q.cosq) * RAD_W'(side_q.cosq);
      side_sq <= side_q;
      rad_sin <= ONE_Q60 - sq_cos;
      side_r  <= side_sq;
    end
  end

  // --------------------------------------------------------------------------
  // sine: second square root cell chain
  // --------------------------------------------------------------------------
  logic [RAD_W-1:0]  r2_rad  [SQRT_STEPS+1];
  logic [REM_W-1:0]  r2_rem  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] r2_root [SQRT_STEPS+1];
  logic [SIDE_W-1:0] side_c_bits;
  side_t             side_c;

  assign r2_rad[0]  = rad_sin;
  assign r2_rem[0]  = '0;
  assign r2_root[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt_b
    tfm_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .rad_in   (r2_rad[k]),
      .rem_in   (r2_rem[k]),
      .root_in  (r2_root[k]),
      .rad_out  (r2_rad[k+1]),
      .rem_out  (r2_rem[k+1]),
      .root_out (r2_root[k+1])
    );
  end

  tfm_delay #(.W(SIDE_W), .DEPTH(SQRT_STEPS)) u_side_c (
    .clk (clk),
    .en  (en),
    .d   (side_r),
    .q   (side_c_bits)
  );
  assign side_c = side_t'(side_c_bits);

  // --------------------------------------------------------------------------
  // angle: arctangent cell chain on (cos, sin)
  // --------------------------------------------------------------------------
  logic signed [CX_W-1:0] cd_x [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] cd_y [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0] cd_z [CORDIC_STEPS+1];
  logic [SIDE_W-1:0]      side_d_bits;
  side_t                  side_d;

  assign cd_x[0] = $signed(CX_W'(side_c.cosq));
  assign cd_y[0] = $signed(CX_W'(r2_root[SQRT_STEPS]));
  assign cd_z[0] = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    tfm_cordic_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (cd_x[k]),
      .y_in  (cd_y[k]),
      .z_in  (cd_z[k]),
      .x_out (cd_x[k+1]),
      .y_out (cd_y[k+1]),
      .z_out (cd_z[k+1])
    );
  end

  tfm_delay #(.W(SIDE_W), .DEPTH(CORDIC_STEPS)) u_side_d (
    .clk (clk),
    .en  (en),
    .d   (side_c),
    .q   (side_d_bits)
  );
  assign side_d = side_t'(side_d_bits);

  // --------------------------------------------------------------------------
  // final stage: clamp to [0, pi/2], fold for negative cosine, round to Q2.16
  // --------------------------------------------------------------------------
  logic signed [CZ_W-1:0] zraw;
  logic [ANGZ_W-1:0]      zc, zf;
  logic [ANGZ_W:0]        zr;
  logic [ANG_W-1:0]       ang;
  logic [ANG_W-1:0]       fin_angle;
  logic [OUT_W-1:0]       fin_mean, fin_spread;

  always_comb begin
    zraw = cd_z[CORDIC_STEPS];
    if (zraw < 0) begin
      zc = '0;
    end else if (zraw > $signed(CZ_W'(Q24_HALF_PI))) begin
      zc = Q24_HALF_PI;
    end else begin
      zc = zraw[ANGZ_W-1:0];
    end
    zf = side_d.dneg ? (Q24_PI - zc) : zc;
    zr = ((ANGZ_W + 1)'(zf) + (ANGZ_W + 1)'(128)) >> 8;
    if (side_d.degen) begin
      ang = Q16_HALF_PI;
    end else if (zr > (ANGZ_W + 1)'(Q16_PI_MAX)) begin
      ang = Q16_PI_MAX;
    end else begin
      ang = zr[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_angle  <= ang;
      fin_mean   <= side_d.mean;
      fin_spread <= side_d.spread;
    end
  end

  // --------------------------------------------------------------------------
  // output register with skid entry
  // --------------------------------------------------------------------------
  logic             leave;
  logic [OUT_W-1:0] skid_mean, skid_spread;
  logic [ANG_W-1:0] skid_angle;

  assign leave = en && vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_ready || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= leave;
        end
      end else if (leave) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        mean_abs_height <= skid_mean;
        tilt_angle      <= skid_angle;
        height_spread   <= skid_spread;
      end else if (leave) begin
        mean_abs_height <= fin_mean;
        tilt_angle      <= fin_angle;
        height_spread   <= fin_spread;
      end
    end else if (leave) begin
      skid_mean   <= fin_mean;
      skid_angle  <= fin_angle;
      skid_spread <= fin_spread;
    end
  end

endmodule

/* hdl/tfm_delay.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_delay
// Register delay line that keeps side data aligned with a cell chain.
// ----------------------------------------------------------------------------
module tfm_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

/* hdl/tfm_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_sqrt_cell
// One digit step of an integer square root: two radicand bits in, one root
// bit out.
// ----------------------------------------------------------------------------
module tfm_sqrt_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tfm_pkg::RAD_W-1:0]   rad_in,
  input  logic [tfm_pkg::REM_W-1:0]   rem_in,
  input  logic [tfm_pkg::ROOT_W-1:0]  root_in,
  output logic [tfm_pkg::RAD_W-1:0]   rad_out,
  output logic [tfm_pkg::REM_W-1:0]   rem_out,
  output logic [tfm_pkg::ROOT_W-1:0]  root_out
);
  import tfm_pkg::*;

  localparam int RW = REM_W + 2;

  logic [RW-1:0] r2;
  logic [RW-1:0] trial;
  logic [RW-1:0] diff;
  logic          ge;

  always_comb begin
    r2    = {rem_in, rad_in[RAD_W-1 -: 2]};
    trial = RW'({root_in, 2'b01});
    diff  = r2 - trial;
    ge    = (r2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_in << 2;
      rem_out  <= ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
      root_out <= {root_in[ROOT_W-2:0], ge};
    end
  end

endmodule

/* hdl/tfm_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_div_cell
// One restoring division step: one dividend bit in, one quotient bit out.
// ----------------------------------------------------------------------------
module tfm_div_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tfm_pkg::DSR_W-1:0]  rem_in,
  input  logic [tfm_pkg::QUO_W-1:0]  bits_in,
  input  logic [tfm_pkg::QUO_W-1:0]  quo_in,
  input  logic [tfm_pkg::DSR_W-1:0]  dsr_in,
  output logic [tfm_pkg::DSR_W-1:0]  rem_out,
  output logic [tfm_pkg::QUO_W-1:0]  bits_out,
  output logic [tfm_pkg::QUO_W-1:0]  quo_out,
  output logic [tfm_pkg::DSR_W-1:0]  dsr_out
);
  import tfm_pkg::*;

  logic [DSR_W:0] r2;
  logic [DSR_W:0] diff;
  logic           ge;

  always_comb begin
    r2   = {rem_in, bits_in[QUO_W-1]};
    diff = r2 - {1'b0, dsr_in};
    ge   = (r2 >= {1'b0, dsr_in});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? diff[DSR_W-1:0] : r2[DSR_W-1:0];
      bits_out <= bits_in << 1;
      quo_out  <= {quo_in[QUO_W-2:0], ge};
      dsr_out  <= dsr_in;
    end
  end

endmodule

/* hdl/tfm_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_cordic_cell
// One vectoring rotation of the arctangent chain.
// ----------------------------------------------------------------------------
module tfm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [tfm_pkg::CX_W-1:0]  x_in,
  input  logic signed [tfm_pkg::CX_W-1:0]  y_in,
  input  logic signed [tfm_pkg::CZ_W-1:0]  z_in,
  output logic signed [tfm_pkg::CX_W-1:0]  x_out,
  output logic signed [tfm_pkg::CX_W-1:0]  y_out,
  output logic signed [tfm_pkg::CZ_W-1:0]  z_out
);
  import tfm_pkg::*;

  localparam logic signed [CZ_W-1:0] ATAN = CZ_W'(atan_q24(STEP));

  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;
  logic                   ypos;

  always_comb begin
    xs   = x_in >>> STEP;
    ys   = y_in >>> STEP;
    ypos = !y_in[CX_W-1] && (|y_in);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ypos) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triangle flatness metrics block.
// ----------------------------------------------------------------------------
// Triangles go in over the input channel, with random gaps on the sender side
// and random stalls on the result side. A scoreboard class works out the mean
// absolute height, height spread and tilt angle of each accepted triangle in
// fixed point. It then compares every result transaction, in order, against
// the oldest pending expectation. The reference normal moves through several
// settings, each written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
  import tfm_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;  // index with no register
  localparam int ITEMS_PER_SET = 325;
  localparam int DRAIN_CYCLES  = 140;              // pipeline latency plus margin
  localparam int STALL_LIMIT   = 4000;

  typedef logic signed [COORD_W-1:0] vtx_set_t [9];

  typedef struct {
    logic [OUT_W-1:0] mean;
    logic [ANG_W-1:0] angle;
    logic [OUT_W-1:0] spread;
  } metrics_t;

  // ---------------------------------------------------------------------------
  // scoreboard: fixed-point metric predictor and the queue of pending results
  // ---------------------------------------------------------------------------
  class metrics_scoreboard;
    logic signed [REF_W-1:0] nrm_x, nrm_y, nrm_z;
    metrics_t pending[$];
    int errors;
    int triangles;
    int results;

    function new();
      nrm_x = REF_X_RESET;
      nrm_y = REF_Y_RESET;
      nrm_z = REF_Z_RESET;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [REF_W-1:0] data);
      case (idx)
        REG_REF_NX: nrm_x = data;
        REG_REF_NY: nrm_y = data;
        REG_REF_NZ: nrm_z = data;
        default: ;  // unused index, ignored
      endcase
    endfunction

    function longint unsigned magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // a*b - c*d as sign and 65-bit magnitude; the partial products are kept
    // exact, just as the datapath keeps them at full width
    function void cross_term(longint a, longint b, longint c, longint d,
                             output bit neg, output bit hi,
                             output longint unsigned lo);
      longint unsigned m1, m2;
      bit s1, s2;
      m1 = magnitude(a) * magnitude(b);
      m2 = magnitude(c) * magnitude(d);
      s1 = (a < 0) != (b < 0);
      s2 = !((c < 0) != (d < 0));
      if (s1 == s2) begin
        lo = m1 + m2;
        hi = lo < m1;
        neg = s1;
      end else if (m1 >= m2) begin
        lo = m1 - m2;
        hi = 0;
        neg = s1;
      end else begin
        lo = m2 - m1;
        hi = 0;
        neg = s2;
      end
    endfunction

    function logic [ANG_W-1:0] tilt_of(vtx_set_t p);
      longint e1x, e1y, e1z, e2x, e2y, e2z;
      bit neg[3], hi[3];
      longint unsigned lo[3], m, sumsq, nlen, dmag, q, s;
      longint n[3], dot, x, y, z, t;
      int len, l, sh;
      longint atan_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214,
        524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2};
      e1x = longint'(p[3]) - p[0];
      e1y = longint'(p[4]) - p[1];
      e1z = longint'(p[5]) - p[2];
      e2x = longint'(p[6]) - p[0];
      e2y = longint'(p[7]) - p[1];
      e2z = longint'(p[8]) - p[2];
      cross_term(e1y, e2z, e1z, e2y, neg[0], hi[0], lo[0]);
      cross_term(e1z, e2x, e1x, e2z, neg[1], hi[1], lo[1]);
      cross_term(e1x, e2y, e1y, e2x, neg[2], hi[2], lo[2]);
      len = 0;
      for (int i = 0; i < 3; i++) begin
        l = 0;
        if (hi[i]) l = 65;
        else for (int b = 0; b < 64; b++) if (lo[i][b]) l = b + 1;
        if (l > len) len = l;
      end
      // zero cross product: degenerate triangle
      if (len == 0) return Q16_HALF_PI;
      // common shift so the largest component lands in [2^23, 2^24)
      for (int i = 0; i < 3; i++) begin
        if (len > 24) begin
          sh = len - 24;
          m = (lo[i] >> sh) | (hi[i] ? (64'd1 << (64 - sh)) : 64'd0);
        end else begin
          m = lo[i] << (24 - len);
        end
        n[i] = neg[i] ? -longint'(m) : longint'(m);
      end
      sumsq = 64'(n[0] * n[0]) + 64'(n[1] * n[1]) + 64'(n[2] * n[2]);
      nlen = int_sqrt(sumsq << 12);
      dot = n[0] * longint'(nrm_x) + n[1] * longint'(nrm_y) + n[2] * longint'(nrm_z);
      dmag = magnitude(dot);
      q = (dmag << 22) / nlen;
      if (q > 64'd1073741824) q = 64'd1073741824;
      s = int_sqrt((64'd1 << 60) - q * q);
      // vectoring rotation on (|cos|, sin)
      x = longint'(q);
      y = longint'(s);
      z = 0;
      for (int i = 0; i < 24; i++) begin
        if (y > 0) begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          x = t;
          z += atan_tab[i];
        end else begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          x = t;
          z -= atan_tab[i];
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(Q24_HALF_PI)) z = Q24_HALF_PI;
      if (dot < 0) z = longint'(Q24_PI) - z;
      q = (64'(z) + 128) >> 8;
      if (q > 64'(Q16_PI_MAX)) q = Q16_PI_MAX;
      return ANG_W'(q);
    endfunction

    function void note_triangle(vtx_set_t p);
      metrics_t r;
      longint unsigned sum;
      longint zmax, zmin;
      sum = magnitude(p[2]) + magnitude(p[5]) + magnitude(p[8]);
      zmax = p[2];
      zmin = p[2];
      if (p[5] > zmax) zmax = p[5];
      if (p[8] > zmax) zmax = p[8];
      if (p[5] < zmin) zmin = p[5];
      if (p[8] < zmin) zmin = p[8];
      r.mean = OUT_W'(sum / 3);
      r.angle = tilt_of(p);
      r.spread = OUT_W'(zmax - zmin);
      pending.insert(pending.size(), r);
      triangles++;
    endfunction

    function void check_result(logic [OUT_W-1:0] mean, logic [ANG_W-1:0] angle,
                               logic [OUT_W-1:0] spread);
      metrics_t e;
      results++;
      if (pending.size() == 0) begin
        $error("result transaction with no triangle pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (mean !== e.mean) begin
        $error("mean_abs_height expected %0d actual %0d", e.mean, mean);
        errors++;
      end
      if (angle !== e.angle) begin
        $error("tilt_angle expected %0d actual %0d", e.angle, angle);
        errors++;
      end
      if (spread !== e.spread) begin
        $error("height_spread expected %0d actual %0d", e.spread, spread);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [REF_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [COORD_W-1:0] p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
  logic out_valid, out_ready;
  logic [OUT_W-1:0] mean_abs_height, height_spread;
  logic [ANG_W-1:0] tilt_angle;

  metrics_scoreboard board = new();
  bit calm;          // no idling on either side in the last part of the run
  int quiet_cycles;
  int reg_writes;

  triangle_flatness_metrics i_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // sample every handshake on the edge, before the driven values move
  always @(posedge clk) begin : monitor
    vtx_set_t v;
    bit seen;
    if (!rst) begin
      seen = 1'b0;
      if (in_valid && in_ready) begin
        v = '{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z};
        board.note_triangle(v);
        seen = 1'b1;
      end
      if (out_valid && out_ready) begin
        board.check_result(mean_abs_height, tilt_angle, height_spread);
        seen = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        board.write_reg(cfg_index, cfg_data);
        reg_writes++;
        seen = 1'b1;
      end
      quiet_cycles <= seen ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // valid stays up across consecutive writes; the caller lowers it
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_reference(logic signed [REF_W-1:0] x, logic signed [REF_W-1:0] y,
                               logic signed [REF_W-1:0] z);
    write_reg(REG_REF_NX, x);
    write_reg(REG_REF_NY, y);
    write_reg(REG_REF_NZ, z);
    write_reg(REG_UNUSED, REF_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // valid stays up between back-to-back triangles; it is lowered only for a gap
  task automatic send_triangle(vtx_set_t v);
    in_valid <= 1'b1;
    {p0_x, p0_y, p0_z} <= {v[0], v[1], v[2]};
    {p1_x, p1_y, p1_z} <= {v[3], v[4], v[5]};
    {p2_x, p2_y, p2_z} <= {v[6], v[7], v[8]};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] corner_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic vtx_set_t random_triangle();
    vtx_set_t v;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2: foreach (v[i]) v[i] = $urandom;
      3, 4: foreach (v[i]) v[i] = $signed($urandom_range(0, 2 << 20)) - (1 << 20);
      5: begin  // near flat: large footprint, small height differences
        foreach (v[i]) v[i] = $urandom;
        k = $urandom;
        for (int i = 2; i < 9; i += 3) v[i] = k + $signed($urandom_range(0, 64)) - 32;
      end
      6: begin  // repeated vertex
        foreach (v[i]) v[i] = $urandom;
        k = 3 * $urandom_range(1, 2);
        for (int i = 0; i < 3; i++) v[k + i] = v[i];
      end
      7: begin  // collinear vertices
        for (int i = 0; i < 6; i++) v[i] = $signed($urandom_range(0, 2 << 24)) - (1 << 24);
        k = $signed($urandom_range(0, 6)) - 3;
        for (int i = 0; i < 3; i++) v[6 + i] = v[i] + k * (v[3 + i] - v[i]);
      end
      default: foreach (v[i]) v[i] = corner_value();
    endcase
    return v;
  endfunction

  task automatic directed_triangles();
    vtx_set_t d[$];
    d.insert(d.size(), '{0, 0, 0, 0, 0, 0, 0, 0, 0});
    // flat in the plane, both windings
    d.insert(d.size(), '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0});
    d.insert(d.size(), '{0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0, 0});
    // standing on edge: normal in the plane
    d.insert(d.size(), '{0, 0, 0, 32'sh10000, 0, 0, 0, 0, 32'sh10000});
    // extreme heights: widest spread and largest mean
    d.insert(d.size(), '{0, 0, 32'sh7fff_ffff, 1, 0, 32'sh8000_0000, 0, 1, 32'sh8000_0000});
    d.insert(d.size(), '{0, 0, 32'sh8000_0000, 5, 0, 32'sh8000_0000, 0, 7, 32'sh8000_0000});
    d.insert(d.size(), '{9, 9, 32'sh7fff_ffff, 1, 0, 32'sh7fff_ffff, 0, 1, 32'sh7fff_ffff});
    // largest edges in every axis
    d.insert(d.size(), '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                         32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000});
    d.insert(d.size(), '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                         32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                         32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000});
    // repeated vertex and collinear vertices
    d.insert(d.size(), '{3, 4, 5, 3, 4, 5, 100, -7, 2});
    d.insert(d.size(), '{0, 0, 0, 10, 20, 30, 20, 40, 60});
    // tiny triangle: one-bit cross product
    d.insert(d.size(), '{0, 0, 0, 1, 0, 0, 0, 1, 0});
    d.insert(d.size(), '{-1, -1, -1, 0, -1, -1, -1, 0, -1});
    foreach (d[i]) send_triangle(d[i]);
  endtask

  task automatic random_triangles(int count);
    repeat (count) send_triangle(random_triangle());
  endtask

  initial begin
    rst <= 1'b1;
    calm = 0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    {p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} <= '0;
    quiet_cycles <= 0;
    reg_writes = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset reference normal
    directed_triangles();
    random_triangles(ITEMS_PER_SET - 13);
    drain();
    set_reference(16'sd16384, 16'sd0, 16'sd0);
    directed_triangles();
    random_triangles(ITEMS_PER_SET - 13);
    drain();
    set_reference(16'sd0, -16'sd16384, -16'sd16384);
    random_triangles(ITEMS_PER_SET);
    drain();
    // zero reference: always a right angle
    set_reference(16'sd0, 16'sd0, 16'sd0);
    random_triangles(ITEMS_PER_SET);
    drain();
    // out-of-range extremes: clamp of the cosine takes over
    set_reference(16'sh8000, 16'sd32767, 16'sh8000);
    random_triangles(ITEMS_PER_SET);
    drain();
    set_reference(REF_W'($signed($urandom_range(0, 32768)) - 16384),
                  REF_W'($signed($urandom_range(0, 32768)) - 16384),
                  REF_W'($signed($urandom_range(0, 32768)) - 16384));
    calm = 1;
    random_triangles(ITEMS_PER_SET);
    drain();

    $display("covered %0d triangles and %0d results over 6 reference normals",
             board.triangles, board.results);
    $display("%0d register writes, %0d mismatches", reg_writes, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* triangle_flatness_metrics.f */
hdl/tfm_pkg.sv
hdl/tfm_delay.sv
hdl/tfm_sqrt_cell.sv
hdl/tfm_div_cell.sv
hdl/tfm_cordic_cell.sv
hdl/triangle_flatness_metrics.sv
bench/tb_top.sv
